/* rtl/btfw_pkg.sv */
// Package with framebuffer geometry, command function codes, character codes and the 3x5 font table.
package btfw_pkg;

  localparam int FB_WIDTH    = 128;
  localparam int FB_PAGES    = 8;
  localparam int STORE_BYTES = FB_WIDTH * FB_PAGES;
  localparam int X_LIMIT     = FB_WIDTH - 5;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int COL_W       = $clog2(FB_WIDTH);
  localparam int PAGE_W      = (FB_PAGES > 1) ? $clog2(FB_PAGES) : 1;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_CASE_OFS = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // Row r of a glyph sits in bits [3r+2:3r]; bit 2 of a row is the left column.
  typedef logic [14:0] glyph_t;

  function automatic glyph_t rows5(input int r0, input int r1, input int r2,
                                   input int r3, input int r4);
    rows5 = {3'(r4), 3'(r3), 3'(r2), 3'(r1), 3'(r0)};
  endfunction

  localparam glyph_t DIGIT_FONT [10] = '{
    rows5(7, 5, 5, 5, 7), rows5(2, 6, 2, 2, 7), rows5(7, 1, 7, 4, 7),
    rows5(7, 1, 7, 1, 7), rows5(5, 5, 7, 1, 1), rows5(7, 4, 7, 1, 7),
    rows5(7, 4, 7, 5, 7), rows5(7, 1, 1, 2, 2), rows5(7, 5, 7, 5, 7),
    rows5(7, 5, 7, 1, 7)
  };

  localparam glyph_t LETTER_FONT [26] = '{
    rows5(2, 5, 7, 5, 5), rows5(6, 5, 6, 5, 6), rows5(3, 4, 4, 4, 3),
    rows5(6, 5, 5, 5, 6), rows5(7, 4, 6, 4, 7), rows5(7, 4, 6, 4, 4),
    rows5(3, 4, 5, 5, 3), rows5(5, 5, 7, 5, 5), rows5(7, 2, 2, 2, 7),
    rows5(1, 1, 1, 5, 2), rows5(5, 5, 6, 5, 5), rows5(4, 4, 4, 4, 7),
    rows5(5, 7, 7, 5, 5), rows5(5, 7, 7, 7, 5), rows5(2, 5, 5, 5, 2),
    rows5(6, 5, 6, 4, 4), rows5(2, 5, 5, 7, 3), rows5(6, 5, 6, 5, 5),
    rows5(3, 4, 2, 1, 6), rows5(7, 2, 2, 2, 2), rows5(5, 5, 5, 5, 7),
    rows5(5, 5, 5, 5, 2), rows5(5, 5, 7, 7, 5), rows5(5, 5, 2, 5, 5),
    rows5(5, 5, 2, 2, 2), rows5(7, 1, 2, 4, 7)
  };

  function automatic glyph_t font_glyph(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      c = c - CH_CASE_OFS;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      font_glyph = DIGIT_FONT[4'(c - CH_ZERO)];
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      font_glyph = LETTER_FONT[5'(c - CH_UPPER_A)];
    end else if (c == CH_DASH) begin
      font_glyph = rows5(0, 0, 7, 0, 0);
    end else if (c == CH_UNDER) begin
      font_glyph = rows5(0, 0, 0, 0, 7);
    end else if (c == CH_COLON) begin
      font_glyph = rows5(0, 2, 0, 2, 0);
    end else if (c == CH_DOT) begin
      font_glyph = rows5(0, 0, 0, 0, 2);
    end else begin
      font_glyph = '0;
    end
  endfunction

endpackage

/* rtl/btfw_if.sv */
// Valid/ready channel interfaces for command words and response words.
interface btfw_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [7:0]                   char_code;
  logic [6:0]                   x_pos;
  logic [5:0]                   y_pos;
  logic [9:0]                   byte_addr;

  modport source (output valid, func, char_code, x_pos, y_pos, byte_addr, input ready);
  modport sink   (input valid, func, char_code, x_pos, y_pos, byte_addr, output ready);
endinterface

interface btfw_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

/* rtl/btfw_ram.sv */
// Generic single-port RAM with registered read data.
module btfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/bitmap_text_framebuffer_writer_core.sv */
// Top level of the 3x5 bitmap text writer over a page-ordered framebuffer.
// Commands arrive as words on the cmd channel: clear the store, draw one
// glyph at (x_pos, y_pos), or read one byte at byte_addr. Every command
// gives exactly one word on the rsp channel; read_data is the byte for a
// read and zero otherwise.
// A draw that is not clipped (x_pos above X_LIMIT) runs six read-modify-write
// passes (three columns, two pages) through the single RAM port, each a
// read state followed by a write state.
// Clear sweeps the store one byte a cycle, 1024 bytes at 128x64.
// After reset the same sweep runs and cmd.ready stays low.
// cmd.ready is high only while the sequencer is idle; a finished response
// sits in an output register, so the next word is taken while it waits.
// If the receiver stalls and a second response is ready, the sequencer
// holds it until the output register frees up.
module bitmap_text_framebuffer_writer_core (
  input  logic      clk,
  input  logic      rst,
  btfw_cmd_if.sink   cmd,
  btfw_rsp_if.source rsp
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DRAW_RD = 3'd2;
  localparam logic [2:0] S_DRAW_WR = 3'd3;
  localparam logic [2:0] S_READ    = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]                   state;
  logic                         clr_reply;
  logic [btfw_pkg::ADDR_W-1:0]  clr_addr;
  logic [1:0]                   col;
  logic                         pg;
  logic [btfw_pkg::COL_W-1:0]   x_base;
  logic [btfw_pkg::PAGE_W-1:0]  page0;
  logic [2:0]                   offset;
  btfw_pkg::glyph_t             glyph;
  logic                         read_ok;
  logic [7:0]                   result;
  logic                         rsp_valid;
  logic [7:0]                   rsp_data;

  logic                         ram_we;
  logic [btfw_pkg::ADDR_W-1:0]  ram_addr;
  logic [7:0]                   ram_wdata;
  logic [7:0]                   ram_rdata;

  logic [4:0]                   col_left, col_mid, col_right, col_bits;
  logic [15:0]                  shifted;
  logic [7:0]                   mask;
  logic [btfw_pkg::PAGE_W-1:0]  page_idx;
  logic                         page_ok;
  logic                         accept;
  logic                         out_free;

  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !rsp_valid || rsp.ready;

  assign cmd.ready     = (state == S_IDLE);
  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_data;

  // Pick the glyph column being written and line it up with the page rows.
  always_comb begin
    for (int r = 0; r < 5; r++) begin
      col_left[r]  = glyph[3*r+2];
      col_mid[r]   = glyph[3*r+1];
      col_right[r] = glyph[3*r];
    end
    case (col)
      2'd0:    col_bits = col_left;
      2'd1:    col_bits = col_mid;
      2'd2:    col_bits = col_right;
      default: col_bits = '0;
    endcase
    shifted  = 16'(col_bits) << offset;
    mask     = pg ? shifted[15:8] : shifted[7:0];
    page_idx = page0 + btfw_pkg::PAGE_W'(pg);
    // The lower page exists only if the glyph does not start in the last page.
    page_ok  = !pg || (page0 != btfw_pkg::PAGE_W'(btfw_pkg::FB_PAGES - 1));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata | mask;
    case (state)
      S_CLEAR: begin
        ram_addr  = clr_addr;
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_DRAW_RD: begin
        ram_addr = btfw_pkg::ADDR_W'({page_idx, x_base + btfw_pkg::COL_W'(col)});
      end
      S_DRAW_WR: begin
        ram_addr = btfw_pkg::ADDR_W'({page_idx, x_base + btfw_pkg::COL_W'(col)});
        ram_we   = page_ok;
      end
      S_IDLE: begin
        ram_addr = cmd.byte_addr;
      end
      default: begin
        ram_addr = '0;
      end
    endcase
  end

  btfw_ram #(
    .WIDTH (8),
    .DEPTH (btfw_pkg::STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_reply <= 1'b0;
      clr_addr  <= '0;
      col       <= '0;
      pg        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == btfw_pkg::ADDR_W'(btfw_pkg::STORE_BYTES - 1)) begin
            clr_addr <= '0;
            state    <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            result <= '0;
            case (cmd.func)
              btfw_pkg::FUNC_CLEAR: begin
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              btfw_pkg::FUNC_DRAW: begin
                x_base <= btfw_pkg::COL_W'(cmd.x_pos);
                page0  <= btfw_pkg::PAGE_W'(cmd.y_pos[5:3]);
                offset <= cmd.y_pos[2:0];
                glyph  <= btfw_pkg::font_glyph(cmd.char_code);
                col    <= '0;
                pg     <= 1'b0;
                if (cmd.x_pos > 7'(btfw_pkg::X_LIMIT)) begin
                  state <= S_DONE;
                end else begin
                  state <= S_DRAW_RD;
                end
              end
              btfw_pkg::FUNC_READ: begin
                read_ok <= ({1'b0, cmd.byte_addr} < 11'(btfw_pkg::STORE_BYTES));
                state   <= S_READ;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DRAW_RD: begin
          state <= S_DRAW_WR;
        end
        S_DRAW_WR: begin
          pg <= !pg;
          if (pg) begin
            col <= col + 1'b1;
          end
          state <= (pg && col == 2'd2) ? S_DONE : S_DRAW_RD;
        end
        S_READ: begin
          result <= read_ok ? ram_rdata : '0;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp_data  <= result;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* bench/tb_bitmap_text_framebuffer_writer_core.sv */
// Self-checking testbench for the 3x5 glyph framebuffer writer core.
module tb_bitmap_text_framebuffer_writer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int HOLD_CYCLES  = 500;
  localparam int ROW_TOTAL    = btfw_pkg::FB_PAGES * 8;
  localparam int FB_W         = btfw_pkg::FB_WIDTH;
  localparam int X_LIM        = btfw_pkg::X_LIMIT;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [6:0] x_pos;
    logic [5:0] y_pos;
    logic [9:0] byte_addr;
  } cmd_word_t;

  // Glyph rows, top first; bit 2 of a row is the leftmost pixel.
  localparam logic [2:0] NUMERAL_ROWS [10][5] = '{
    '{7, 5, 5, 5, 7}, '{2, 6, 2, 2, 7}, '{7, 1, 7, 4, 7}, '{7, 1, 7, 1, 7},
    '{5, 5, 7, 1, 1}, '{7, 4, 7, 1, 7}, '{7, 4, 7, 5, 7}, '{7, 1, 1, 2, 2},
    '{7, 5, 7, 5, 7}, '{7, 5, 7, 1, 7}
  };

  localparam logic [2:0] ALPHA_ROWS [26][5] = '{
    '{2, 5, 7, 5, 5}, '{6, 5, 6, 5, 6}, '{3, 4, 4, 4, 3}, '{6, 5, 5, 5, 6},
    '{7, 4, 6, 4, 7}, '{7, 4, 6, 4, 4}, '{3, 4, 5, 5, 3}, '{5, 5, 7, 5, 5},
    '{7, 2, 2, 2, 7}, '{1, 1, 1, 5, 2}, '{5, 5, 6, 5, 5}, '{4, 4, 4, 4, 7},
    '{5, 7, 7, 5, 5}, '{5, 7, 7, 7, 5}, '{2, 5, 5, 5, 2}, '{6, 5, 6, 4, 4},
    '{2, 5, 5, 7, 3}, '{6, 5, 6, 5, 5}, '{3, 4, 2, 1, 6}, '{7, 2, 2, 2, 2},
    '{5, 5, 5, 5, 7}, '{5, 5, 5, 5, 2}, '{5, 5, 7, 7, 5}, '{5, 5, 2, 5, 5},
    '{5, 5, 2, 2, 2}, '{7, 1, 2, 4, 7}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  btfw_cmd_if cmd_bus ();
  btfw_rsp_if rsp_bus ();

  bitmap_text_framebuffer_writer_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  logic [7:0] pixel_bytes [btfw_pkg::STORE_BYTES];
  cmd_word_t  cmd_backlog [$];
  logic [7:0] expected_bytes [$];
  cmd_word_t  on_bus;

  int n_queued, n_accepted, n_checked, n_errors, cycle_count;
  int n_clears, n_draws, n_clipped, n_reads, n_lit_reads, n_unused;
  int burst_left, gap_left, hold_left, mode_left, stall_mode;
  bit hold_done;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [4:0][2:0] glyph_of(input logic [7:0] code);
    logic [7:0] c;
    logic [4:0][2:0] g;
    c = code;
    g = '0;
    if (c >= btfw_pkg::CH_LOWER_A && c <= btfw_pkg::CH_LOWER_Z)
      c = c - btfw_pkg::CH_CASE_OFS;
    if (c >= btfw_pkg::CH_ZERO && c <= btfw_pkg::CH_NINE) begin
      for (int r = 0; r < 5; r++) g[r] = NUMERAL_ROWS[c - btfw_pkg::CH_ZERO][r];
    end else if (c >= btfw_pkg::CH_UPPER_A && c <= btfw_pkg::CH_UPPER_Z) begin
      for (int r = 0; r < 5; r++) g[r] = ALPHA_ROWS[c - btfw_pkg::CH_UPPER_A][r];
    end else if (c == btfw_pkg::CH_DASH) begin
      g[2] = 3'd7;
    end else if (c == btfw_pkg::CH_UNDER) begin
      g[4] = 3'd7;
    end else if (c == btfw_pkg::CH_COLON) begin
      g[1] = 3'd2;
      g[3] = 3'd2;
    end else if (c == btfw_pkg::CH_DOT) begin
      g[4] = 3'd2;
    end
    return g;
  endfunction

  // Updates the pixel image for one accepted word and yields the response byte.
  task automatic render_and_predict(input cmd_word_t w, output logic [7:0] rd);
    logic [4:0][2:0] g;
    int py, idx;
    rd = '0;
    case (w.func)
      btfw_pkg::FUNC_CLEAR: begin
        foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
        n_clears++;
      end
      btfw_pkg::FUNC_DRAW: begin
        n_draws++;
        if (w.x_pos > X_LIM) begin
          n_clipped++;
        end else begin
          g = glyph_of(w.char_code);
          for (int r = 0; r < 5; r++) begin
            py = w.y_pos + r;
            if (py >= ROW_TOTAL) continue;
            for (int k = 0; k < 3; k++) begin
              if (g[r][2-k]) begin
                idx = (py / 8) * FB_W + w.x_pos + k;
                if (idx < btfw_pkg::STORE_BYTES) pixel_bytes[idx][py % 8] = 1'b1;
              end
            end
          end
        end
      end
      btfw_pkg::FUNC_READ: begin
        n_reads++;
        if (w.byte_addr < btfw_pkg::STORE_BYTES) rd = pixel_bytes[w.byte_addr];
        if (rd != 0) n_lit_reads++;
      end
      default: begin
        n_unused++;
      end
    endcase
  endtask

  task automatic queue_raw(input logic [1:0] f, input logic [7:0] code,
                           input logic [6:0] x, input logic [5:0] y,
                           input logic [9:0] addr);
    cmd_word_t w;
    w.func      = f;
    w.char_code = code;
    w.x_pos     = x;
    w.y_pos     = y;
    w.byte_addr = addr;
    cmd_backlog.push_back(w);
    n_queued++;
  endtask

  // Fields a command does not use carry random values.
  task automatic queue_draw(input logic [7:0] code, input int x, input int y);
    queue_raw(btfw_pkg::FUNC_DRAW, code, 7'(x), 6'(y), 10'($urandom_range(0, 1023)));
  endtask

  task automatic queue_read(input int addr);
    queue_raw(btfw_pkg::FUNC_READ, 8'($urandom_range(0, 255)),
              7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)), 10'(addr));
  endtask

  task automatic queue_clear();
    queue_raw(btfw_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)),
              7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
              10'($urandom_range(0, 1023)));
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return btfw_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      3, 4, 5: return btfw_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
      6, 7:    return btfw_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
      8: begin
        case ($urandom_range(0, 3))
          0: return btfw_pkg::CH_DASH;
          1: return btfw_pkg::CH_UNDER;
          2: return btfw_pkg::CH_COLON;
          default: return btfw_pkg::CH_DOT;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A short string at a random origin, then reads inside the glyph boxes.
  task automatic queue_text_run();
    int len, x0, y0, x, pg, lo_pg, hi_pg;
    bit full;
    len  = $urandom_range(1, 6);
    x0   = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 100) : $urandom_range(0, 127);
    y0   = $urandom_range(0, 63);
    full = ($urandom_range(0, 4) == 0);
    lo_pg = y0 / 8;
    hi_pg = ((y0 + 4) / 8 < btfw_pkg::FB_PAGES) ? (y0 + 4) / 8 : lo_pg;
    for (int i = 0; i < len; i++) begin
      x = x0 + 4 * i;
      if (x > 127) break;
      queue_draw(pick_char(), x, y0);
      if ($urandom_range(0, 4) == 0)
        queue_draw(pick_char(), x + $urandom_range(0, 2), (y0 + $urandom_range(0, 3)) % 64);
    end
    for (int i = 0; i < len; i++) begin
      x = x0 + 4 * i;
      if (x > 127) break;
      if (full) begin
        for (int k = 0; k < 3; k++) begin
          queue_read(lo_pg * FB_W + ((x + k) % FB_W));
          if (hi_pg != lo_pg) queue_read(hi_pg * FB_W + ((x + k) % FB_W));
        end
      end else begin
        repeat (2) begin
          pg = ($urandom_range(0, 1) != 0) ? hi_pg : lo_pg;
          queue_read(pg * FB_W + ((x + $urandom_range(0, 2)) % FB_W));
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || expected_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    bit mid_pause;
    foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: each glyph class, both edges of the x clip and rows off the bottom.
    queue_read(0);
    queue_draw(btfw_pkg::CH_ZERO, 0, 0);
    queue_read(0);
    queue_draw(btfw_pkg::CH_NINE, 20, 40);
    queue_read(5 * FB_W + 21);
    queue_draw(btfw_pkg::CH_UPPER_A, X_LIM, 61);
    queue_read(7 * FB_W + X_LIM + 1);
    queue_draw(btfw_pkg::CH_LOWER_Z, X_LIM + 1, 0);
    queue_read(X_LIM + 1);
    queue_draw(btfw_pkg::CH_DASH, 4, 6);
    queue_read(FB_W + 4);
    queue_draw(btfw_pkg::CH_UNDER, 8, 63);
    queue_draw(btfw_pkg::CH_COLON, 12, 20);
    queue_draw(btfw_pkg::CH_DOT, 16, 30);
    queue_draw(btfw_pkg::CH_UPPER_Z, 24, 50);
    queue_draw(btfw_pkg::CH_LOWER_A, 28, 10);
    queue_draw(8'hFF, 32, 0);
    queue_draw(8'h00, 36, 0);
    queue_draw(btfw_pkg::CH_ZERO, 127, 0);
    queue_read(7 * FB_W + 8);
    queue_read(1023);
    queue_raw(FUNC_UNUSED, 8'hFF, 7'h7F, 6'h3F, 10'h3FF);
    queue_clear();
    queue_read(0);
    wait_drained();

    target = n_queued + RANDOM_ITEMS;
    mid_pause = 1'b0;
    while (n_queued < target) begin
      case ($urandom_range(0, 99))
        0, 1: queue_clear();
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
          queue_raw(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                    10'($urandom_range(0, 1023)));
        12, 13, 14, 15, 16:
          queue_read($urandom_range(0, 1023));
        default: queue_text_run();
      endcase
      if (!mid_pause && n_queued > target - RANDOM_ITEMS / 2) begin
        wait_drained();
        mid_pause = 1'b1;
      end
      while (cmd_backlog.size() > 64) @(posedge clk);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d clears, %0d draws (%0d clipped), %0d reads, %0d unused commands",
             n_clears, n_draws, n_clipped, n_reads, n_unused);
    $display("%0d response words checked, %0d reads returned lit pixels",
             n_checked, n_lit_reads);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Command driver: bursts of words separated by random gaps.
  always @(posedge clk) begin
    logic [7:0] rd;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        render_and_predict(on_bus, rd);
        expected_bytes.push_back(rd);
        void'(cmd_backlog.pop_front());
        n_accepted++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(10, 40);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
      end
      if (cmd_bus.valid && !cmd_bus.ready) begin
        // Hold the word until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        cmd_bus.valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        on_bus = cmd_backlog[0];
        cmd_bus.valid     <= 1'b1;
        cmd_bus.func      <= on_bus.func;
        cmd_bus.char_code <= on_bus.char_code;
        cmd_bus.x_pos     <= on_bus.x_pos;
        cmd_bus.y_pos     <= on_bus.y_pos;
        cmd_bus.byte_addr <= on_bus.byte_addr;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // Response monitor with its own stall pattern and one long hold-off.
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      hold_left  = 0;
      hold_done  = 1'b0;
      mode_left  = 0;
      stall_mode = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        n_checked++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected response word, expected none, got read_data %02h",
                   $time, rsp_bus.read_data);
          n_errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (rsp_bus.read_data !== want) begin
            $display("%0t: read_data mismatch, expected %02h, got %02h",
                     $time, want, rsp_bus.read_data);
            n_errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!hold_done && n_accepted >= 300) begin
        // Back-pressure long enough for the core to stop taking commands.
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_bus.ready <= 1'b0;
      end else begin
        if (mode_left <= 0) begin
          mode_left  = $urandom_range(20, 200);
          stall_mode = $urandom_range(0, 3);
        end
        mode_left--;
        case (stall_mode)
          0: rsp_bus.ready <= 1'b1;
          1: rsp_bus.ready <= ($urandom_range(0, 1) == 0);
          2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d words still expected",
               $time, cycle_count, expected_bytes.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule
